FILE: rtl/sds_pkg.sv
// ----------------------------------------------------------------------------
// sds_pkg: shared types and constants of the disconnect sequencer
// input beat, result beat, state codes, chip constants and status decode
// ----------------------------------------------------------------------------
package sds_pkg;

  typedef struct packed {
    logic        operation;
    logic [2:0]  unit;
    logic [23:0] byte_count;
    logic        data_in;
    logic [7:0]  scsi_status;
    logic [7:0]  command_phase;
    logic [7:0]  target_status;
    logic [7:0]  source_id;
    logic [7:0]  message_byte;
    logic [23:0] transfer_count_now;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [2:0]  unit_res;
    logic [7:0]  chip_command;
    logic [7:0]  phase_write;
    logic [23:0] transfer_count;
    logic        data_in_res;
    logic        command_ok;
    logic [7:0]  target_status_res;
    logic        last;
  } out_beat_t;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_STARTING  = 3'd1;
  localparam logic [2:0] ST_RESUMING  = 3'd2;
  localparam logic [2:0] ST_DEAD      = 3'd3;
  localparam logic [2:0] ST_MESSAGING = 3'd4;
  localparam logic [2:0] ST_ENDING    = 3'd5;

  localparam logic [3:0] K_QUEUED   = 4'd0;
  localparam logic [3:0] K_REJECTED = 4'd1;
  localparam logic [3:0] K_SELECT   = 4'd2;
  localparam logic [3:0] K_RESEL    = 4'd3;
  localparam logic [3:0] K_PHASE    = 4'd4;
  localparam logic [3:0] K_SAVE     = 4'd5;
  localparam logic [3:0] K_EXPECT   = 4'd6;
  localparam logic [3:0] K_DONE     = 4'd7;
  localparam logic [3:0] K_ABORTED  = 4'd8;
  localparam logic [3:0] K_DISC     = 4'd9;
  localparam logic [3:0] K_MSG      = 4'd10;
  localparam logic [3:0] K_DEAD     = 4'd11;

  localparam logic [3:0] A_DONE   = 4'd0;
  localparam logic [3:0] A_DEAD   = 4'd1;
  localparam logic [3:0] A_RESELQ = 4'd2;
  localparam logic [3:0] A_RESEL  = 4'd3;
  localparam logic [3:0] A_PHASE  = 4'd4;
  localparam logic [3:0] A_ABORT  = 4'd5;
  localparam logic [3:0] A_SAVE   = 4'd6;
  localparam logic [3:0] A_DISC   = 4'd7;
  localparam logic [3:0] A_MSG    = 4'd8;
  localparam logic [3:0] A_EXPECT = 4'd9;

  localparam logic [7:0] PH_STATUS  = 8'h60;
  localparam logic [7:0] PH_RESEL   = 8'h44;
  localparam logic [7:0] PH_RESUME  = 8'h45;
  localparam logic [7:0] PH_END     = 8'h46;
  localparam logic [7:0] CMD_XFER   = 8'hA0;
  localparam logic [7:0] MSG_DISC   = 8'h03;
  localparam logic [7:0] START_RST  = 8'h09;

  function automatic logic [3:0] code_of(input logic [7:0] ss);
    logic [3:0] c;
    case (ss)
      8'h42:   c = 4'd0;
      8'h21:   c = 4'd2;
      8'h85:   c = 4'd3;
      8'h81:   c = 4'd4;
      8'h4F:   c = 4'd5;
      8'h20:   c = 4'd6;
      8'h4B:   c = 4'd7;
      8'h16:   c = 4'd8;
      default: c = 4'd1;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] action_of(input logic [2:0] st, input logic [3:0] c);
    logic [3:0] a;
    a = A_DEAD;
    case (st)
      ST_IDLE: if (c == 4'd4) a = A_RESEL;
      ST_STARTING: begin
        case (c)
          4'd0: a = A_ABORT;
          4'd2: a = A_SAVE;
          4'd3: a = A_DISC;
          4'd4: a = A_RESELQ;
          4'd5: a = A_MSG;
          4'd7: a = A_EXPECT;
          4'd8: a = A_DONE;
          default: a = A_DEAD;
        endcase
      end
      ST_RESUMING: begin
        case (c)
          4'd2: a = A_SAVE;
          4'd3: a = A_DISC;
          4'd5: a = A_MSG;
          4'd7: a = A_EXPECT;
          4'd8: a = A_DONE;
          default: a = A_DEAD;
        endcase
      end
      ST_MESSAGING: if (c == 4'd6) a = A_PHASE;
      ST_ENDING: if (c == 4'd8) a = A_DONE;
      default: a = A_DEAD;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/sds_out_stage.sv
// ----------------------------------------------------------------------------
// sds_out_stage: result register with a one-deep second-result slot
// presents the first result, then the held second one (if two) on the next cycle
// ----------------------------------------------------------------------------
module sds_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  logic                 two,
  input  sds_pkg::out_beat_t   first,
  input  sds_pkg::out_beat_t   second,
  output logic                 pend,
  output logic                 out_strobe,
  output sds_pkg::out_beat_t   out_beat
);
  logic               strobe_r;
  logic               pend_r;
  sds_pkg::out_beat_t beat_r;
  sds_pkg::out_beat_t hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
      pend_r   <= 1'b0;
    end else if (pend_r) begin
      strobe_r <= 1'b1;
      pend_r   <= 1'b0;
    end else begin
      strobe_r <= load;
      pend_r   <= load & two;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r) begin
      beat_r <= hold_r;
    end else if (load) begin
      beat_r <= first;
      hold_r <= second;
    end
  end

  assign pend       = pend_r;
  assign out_strobe = strobe_r;
  assign out_beat   = beat_r;
endmodule

FILE: rtl/scsi_disconnect_sequencer_unit.sv
// ----------------------------------------------------------------------------
// scsi_disconnect_sequencer_unit: initiator command sequencer
// ----------------------------------------------------------------------------
// Input channel: drive in_beat and pulse start while busy is low; the beat is
// taken at that edge. operation 0 queues a command for a unit, 1 hands over a
// chip interrupt event. Results appear on out_beat with out_strobe high for
// one cycle each, the last one flagged by its last bit; they cannot be held.
// The first result is registered at the accepting edge. An item yields one
// or two results; with two, the second follows in the next cycle and busy
// is high while the first is shown, so the next item waits until the second
// result is registered. All state updates happen at the accepting edge.
// cfg_we writes the chip start command (0x09 after reset).
// Reset (synchronous, active low) empties the start queue and every unit's
// command ring and puts the controller in idle; command storage itself is not
// cleared and is never read before it is written.
// ----------------------------------------------------------------------------
module scsi_disconnect_sequencer_unit #(
  parameter int UNITS         = 8,
  parameter int CMDS_PER_UNIT = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sds_pkg::in_beat_t  in_beat,
  output logic               out_strobe,
  output sds_pkg::out_beat_t out_beat,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);
  localparam int CW = (CMDS_PER_UNIT > 1) ? $clog2(CMDS_PER_UNIT) : 1;
  localparam int NW = $clog2(CMDS_PER_UNIT + 1);
  localparam int SLOTS = UNITS * CMDS_PER_UNIT;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [7:0]  start_cmd_r;
  logic [2:0]  state_r, state_nxt;
  logic [2:0]  cur_r, cur_nxt;
  logic [2:0]  sfifo_r [8];
  logic [2:0]  shead_r, shead_nxt, stail_r, stail_nxt;
  logic [3:0]  sfill_r, sfill_nxt;
  logic [NW-1:0] pcnt_r [UNITS];
  logic [CW-1:0] phead_r [UNITS];
  logic [24:0] store_r [SLOTS];
  logic [23:0] saved_r [UNITS];

  logic pend, take;
  sds_pkg::in_beat_t b;
  sds_pkg::out_beat_t r0, r1;
  logic two;

  assign busy = pend;
  assign take = start & ~pend;
  assign b    = in_beat;

  function automatic logic [SW-1:0] slot_of(input logic [2:0] u, input logic [CW-1:0] h);
    return SW'(int'(u) * CMDS_PER_UNIT + ((CMDS_PER_UNIT > 1) ? int'(h) : 0));
  endfunction

  function automatic logic [CW-1:0] inc_h(input logic [CW-1:0] h, input logic [NW-1:0] n);
    logic [NW:0] s;
    s = {1'b0, n} + (NW+1)'(h);
    if (s >= (NW+1)'(CMDS_PER_UNIT)) s = s - (NW+1)'(CMDS_PER_UNIT);
    return (CMDS_PER_UNIT > 1) ? s[CW-1:0] : '0;
  endfunction

  // next-state decisions
  logic        q_ok, q_push;
  logic [2:0]  qu;
  logic [3:0]  act;
  logic        pop_ring, push_cur, push_q, do_start, save_wr;
  logic [2:0]  su, ru;
  logic [24:0] se, re, fe;
  logic [3:0]  fill_a;

  always_comb begin
    r0 = '0; r1 = '0; two = 1'b0;
    state_nxt = state_r; cur_nxt = cur_r;
    q_ok = 1'b0; q_push = 1'b0; push_cur = 1'b0; pop_ring = 1'b0;
    do_start = 1'b0; save_wr = 1'b0;
    qu = b.unit;
    act = sds_pkg::action_of(state_r, sds_pkg::code_of(b.scsi_status));
    ru = b.source_id[2:0];
    re = store_r[slot_of(ru, phead_r[ru])];
    fe = store_r[slot_of(cur_r, phead_r[cur_r])];
    if (!b.operation) begin
      r0.unit_res = qu;
      if (int'(qu) >= UNITS || pcnt_r[qu] >= NW'(CMDS_PER_UNIT)) begin
        r0.kind = sds_pkg::K_REJECTED;
      end else begin
        r0.kind = sds_pkg::K_QUEUED;
        q_ok = 1'b1;
        q_push = (pcnt_r[qu] == '0);
        do_start = q_push && state_r == sds_pkg::ST_IDLE;
      end
    end else begin
      r0.unit_res = cur_r;
      case (act)
        sds_pkg::A_DONE, sds_pkg::A_ABORT: begin
          r0.kind = (act == sds_pkg::A_DONE) ? sds_pkg::K_DONE : sds_pkg::K_ABORTED;
          if (act == sds_pkg::A_DONE && b.command_phase == sds_pkg::PH_STATUS) begin
            r0.command_ok = 1'b1;
            r0.target_status_res = b.target_status;
          end
          if (pcnt_r[cur_r] != '0) begin
            pop_ring = 1'b1;
            r0.data_in_res = fe[24];
            push_cur = (pcnt_r[cur_r] != NW'(1));
          end
          state_nxt = sds_pkg::ST_IDLE;
          do_start = 1'b1;
        end
        sds_pkg::A_RESELQ, sds_pkg::A_RESEL: begin
          push_cur = (act == sds_pkg::A_RESELQ);
          if (int'(ru) >= UNITS || pcnt_r[ru] == '0) begin
            r0.kind = sds_pkg::K_DEAD;
            state_nxt = sds_pkg::ST_DEAD;
          end else begin
            cur_nxt = ru;
            state_nxt = sds_pkg::ST_RESUMING;
            r0.kind = sds_pkg::K_RESEL;
            r0.unit_res = ru;
            r0.chip_command = start_cmd_r;
            r0.phase_write = sds_pkg::PH_RESEL;
            r0.transfer_count = saved_r[ru];
            r0.data_in_res = re[24];
          end
        end
        sds_pkg::A_PHASE: begin
          state_nxt = sds_pkg::ST_RESUMING;
          r0.kind = sds_pkg::K_PHASE;
          r0.chip_command = start_cmd_r;
          r0.phase_write = sds_pkg::PH_RESUME;
          r0.transfer_count = saved_r[cur_r];
        end
        sds_pkg::A_SAVE: begin
          save_wr = 1'b1;
          state_nxt = sds_pkg::ST_RESUMING;
          r0.kind = sds_pkg::K_SAVE;
          r0.chip_command = start_cmd_r;
          r0.transfer_count = b.transfer_count_now;
        end
        sds_pkg::A_DISC: begin
          r0.kind = sds_pkg::K_DISC;
          state_nxt = sds_pkg::ST_IDLE;
          do_start = 1'b1;
        end
        sds_pkg::A_MSG: begin
          r0.chip_command = sds_pkg::CMD_XFER;
          if (b.message_byte == sds_pkg::MSG_DISC) begin
            r0.kind = sds_pkg::K_MSG;
            state_nxt = sds_pkg::ST_MESSAGING;
          end else begin
            r0.kind = sds_pkg::K_DEAD;
            state_nxt = sds_pkg::ST_DEAD;
          end
        end
        sds_pkg::A_EXPECT: begin
          state_nxt = sds_pkg::ST_ENDING;
          r0.kind = sds_pkg::K_EXPECT;
          r0.chip_command = start_cmd_r;
          r0.phase_write = sds_pkg::PH_END;
        end
        default: begin
          r0.kind = sds_pkg::K_DEAD;
          state_nxt = sds_pkg::ST_DEAD;
        end
      endcase
    end
    push_q = q_push | push_cur;
    // start fifo push then optional pop
    stail_nxt = stail_r; fill_a = sfill_r;
    if (push_q && sfill_r < 4'd8) begin
      stail_nxt = stail_r + 3'd1;
      fill_a = sfill_r + 4'd1;
    end
    shead_nxt = shead_r; sfill_nxt = fill_a;
    su = (push_q && sfill_r == 4'd0) ? (q_push ? qu : cur_r) : sfifo_r[shead_r];
    if (int'(su) >= UNITS) su = 3'd0;
    // a select sees the ring after a finish; the only self-read is a requeued unit
    se = store_r[slot_of(su, (pop_ring && su == cur_r) ?
                  inc_h(phead_r[cur_r], NW'(1)) : phead_r[su])];
    if (q_ok && q_push && su == qu) se = {b.data_in, b.byte_count};
    if (do_start && fill_a != 4'd0) begin
      shead_nxt = shead_r + 3'd1;
      sfill_nxt = fill_a - 4'd1;
      cur_nxt = su;
      state_nxt = sds_pkg::ST_STARTING;
      two = 1'b1;
      r1.kind = sds_pkg::K_SELECT;
      r1.unit_res = su;
      r1.chip_command = start_cmd_r;
      r1.transfer_count = se[23:0];
      r1.data_in_res = se[24];
      r1.last = 1'b1;
    end else begin
      do_start = 1'b0;
      r0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_cmd_r <= sds_pkg::START_RST;
    end else if (cfg_we) begin
      start_cmd_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sds_pkg::ST_IDLE;
      cur_r   <= 3'd0;
      shead_r <= 3'd0;
      stail_r <= 3'd0;
      sfill_r <= 4'd0;
      for (int i = 0; i < UNITS; i++) begin
        pcnt_r[i]  <= '0;
        phead_r[i] <= '0;
      end
    end else if (take) begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      shead_r <= shead_nxt;
      stail_r <= stail_nxt;
      sfill_r <= sfill_nxt;
      if (q_ok) pcnt_r[qu] <= pcnt_r[qu] + NW'(1);
      if (pop_ring) begin
        pcnt_r[cur_r]  <= pcnt_r[cur_r] - NW'(1);
        phead_r[cur_r] <= inc_h(phead_r[cur_r], NW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (push_q && sfill_r < 4'd8) sfifo_r[stail_r] <= q_push ? qu : cur_r;
      if (q_ok) store_r[slot_of(qu, inc_h(phead_r[qu], pcnt_r[qu]))] <= {b.data_in, b.byte_count};
      if (save_wr) saved_r[cur_r] <= b.transfer_count_now;
      if (do_start) saved_r[su] <= se[23:0];
    end
  end

  sds_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (take),
    .two        (two),
    .first      (r0),
    .second     (r1),
    .pend       (pend),
    .out_strobe (out_strobe),
    .out_beat   (out_beat)
  );
endmodule

FILE: rtl/sds_checker.sv
// ----------------------------------------------------------------------------
// sds_port_checks: port-level checks of the disconnect sequencer
// result timing and pairing of two-beat items
// ----------------------------------------------------------------------------
module sds_port_checks (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_strobe,
  input sds_pkg::out_beat_t out_beat
);
  // every accepted item shows a result next cycle
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_strobe) else $error("no result after accept");

  // a non-last beat is followed by the next beat, under busy
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_beat.last) |-> busy) else $error("second beat not held");

  a_pair2: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_beat.last) |=> (out_strobe && out_beat.last))
    else $error("second beat missing");

  // a second beat is always a select
  a_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_beat.last) |=> out_beat.kind == sds_pkg::K_SELECT)
    else $error("second beat not a select");
endmodule

bind scsi_disconnect_sequencer_unit sds_port_checks u_sds_port_checks (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_beat   (out_beat)
);
